/* src/svs_pkg.sv */
// Shared constants and types for the smoothed velocity speed block.
`default_nettype none

package svs_pkg;

	localparam int MAX_WINDOW  = 8;
	localparam int SAMPLE_BITS = 16;
	localparam int NUM_AXES    = 3;
	localparam int CFG_W       = 4;
	localparam int LEN_RESET   = 5;

	localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
	localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
	localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

	// divider: two quotient bits per cycle over a zero-padded dividend
	localparam int QUO_W   = SAMPLE_BITS;
	localparam int DIV_CYC = (SUM_W + 1) / 2;
	localparam int DIV_W   = 2 * DIV_CYC;

	// square root: two root bits per cycle
	localparam int SQ_W     = 2 * SAMPLE_BITS + 2;
	localparam int ROOT_CYC = (SQ_W / 2 + 1) / 2;
	localparam int RAD_W    = 4 * ROOT_CYC;
	localparam int RT_W     = 2 * ROOT_CYC;

	// km/h scale: x*18, then /5 as multiply by ceil(2^26/5), exact below 2^26
	localparam int X18_W    = RT_W + 5;
	localparam int RECIP_W  = 24;
	localparam int RECIP_SH = 26;
	localparam logic [RECIP_W-1:0] RECIP5 = 24'd13421773;

	localparam int KMH_W = 18;
	localparam int OUT_MAX = (2 ** KMH_W) - 1;

	localparam int MAX_CYC = (DIV_CYC > ROOT_CYC) ? DIV_CYC : ROOT_CYC;
	localparam int STEP_W  = $clog2(MAX_CYC + 1);

	localparam int IN_W        = NUM_AXES * SAMPLE_BITS;
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((KMH_W + 7) / 8) * 8;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	// one queued job: per-axis |sum| and the count it is averaged over
	typedef struct packed {
		logic [NUM_AXES-1:0][SUM_W-1:0] abs_sum;
		logic [CNT_W-1:0]               cnt;
	} svs_item_t;

endpackage

`default_nettype wire

/* src/svs_front.sv */
// Front end: sample windows, running sums, fill count and window length register.
`default_nettype none

module svs_front
	import svs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,     // vel_x, vel_y, vel_z
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CFG_W-1:0] cfg_data,
	output logic                  q_valid,
	input  wire logic             q_ready,
	output svs_item_t             q_item
);

	sample_t          win_q [NUM_AXES][MAX_WINDOW];
	sum_t             sum_q [NUM_AXES];
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] len_q;
	logic [SLOT_W-1:0] slot_q;

	sample_t          vel   [NUM_AXES];
	sample_t          old_s [NUM_AXES];
	logic signed [SUM_W:0] nsum [NUM_AXES];
	sum_t             sum_d [NUM_AXES];
	logic             full;
	logic             accept;
	logic             cfg_wr;
	logic [CNT_W-1:0] len_d;
	logic [SLOT_W-1:0] slot_d;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	// config wins over a sample in the same cycle
	assign s_tready  = q_ready && !cfg_valid;
	assign accept    = s_tvalid && s_tready;
	assign q_valid   = accept;
	assign full      = (fill_q >= len_q);

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			vel[a]   = s_tdata[a*SAMPLE_BITS +: SAMPLE_BITS];
			old_s[a] = full ? win_q[a][slot_q] : '0;
			nsum[a]  = (SUM_W+1)'(sum_q[a]) - (SUM_W+1)'(old_s[a]) + (SUM_W+1)'(vel[a]);
			sum_d[a] = nsum[a][SUM_W-1:0];
			q_item.abs_sum[a] = sum_d[a][SUM_W-1] ? (~sum_d[a] + 1'b1) : sum_d[a];
		end
		q_item.cnt = full ? fill_q : fill_q + 1'b1;
	end

	always_comb begin
		if (int'(slot_q) + 1 == int'(len_q)) begin
			slot_d = '0;
		end else begin
			slot_d = slot_q + 1'b1;
		end
	end

	// zero means one sample, anything above the store depth saturates
	always_comb begin
		if (cfg_data == '0) begin
			len_d = CNT_W'(1);
		end else if (int'(cfg_data) > MAX_WINDOW) begin
			len_d = CNT_W'(MAX_WINDOW);
		end else begin
			len_d = CNT_W'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= CNT_W'(LEN_RESET);
			fill_q <= '0;
			slot_q <= '0;
			for (int a = 0; a < NUM_AXES; a++) begin
				sum_q[a] <= '0;
			end
		end else if (cfg_wr) begin
			len_q  <= len_d;
			fill_q <= '0;
			slot_q <= '0;
			for (int a = 0; a < NUM_AXES; a++) begin
				sum_q[a] <= '0;
			end
		end else if (accept) begin
			fill_q <= q_item.cnt;
			slot_q <= slot_d;
			for (int a = 0; a < NUM_AXES; a++) begin
				sum_q[a] <= sum_d[a];
			end
		end
	end

	// window slots are only read once written since the last clear
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				win_q[a][slot_q] <= vel[a];
			end
		end
	end

	a_fill_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= len_q)
		else $error("fill count exceeds window length");

	a_slot_lt_len: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(slot_q) < len_q)
		else $error("write slot outside window");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (fill_q == '0) && (slot_q == '0))
		else $error("config write did not clear the store");

endmodule

`default_nettype wire

/* src/svs_queue.sv */
// Two-entry job queue between front and back end.
`default_nettype none

module svs_queue
	import svs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire svs_item_t in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output svs_item_t      out_item
);

	svs_item_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign in_ready  = (count_q != QCNT_W'(QDEPTH));
	assign out_valid = (count_q != '0);
	assign out_item  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count overflow");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue lost an entry");

endmodule

`default_nettype wire

/* src/svs_back.sv */
// Back end: per-axis divide, sum of squares, integer square root, km/h scaling.
`default_nettype none

module svs_back
	import svs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	output logic                  q_ready,
	input  wire svs_item_t        q_item,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [KMH_W-1:0]      m_tdata     // speed_kmh
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DIV   = 6'b000010,
		ST_SQR   = 6'b000100,
		ST_ROOT  = 6'b001000,
		ST_SCALE = 6'b010000,
		ST_DONE  = 6'b100000
	} back_state_t;

	localparam int SCL_W = X18_W + RECIP_W;
	localparam int KF_W  = SCL_W - RECIP_SH;

	back_state_t          state_q;
	logic [STEP_W-1:0]    step_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_W-1:0]     dvd_q  [NUM_AXES];
	logic [CNT_W-1:0]     drem_q [NUM_AXES];
	logic [2*QUO_W-1:0]   prod_q;
	logic [SQ_W-1:0]      acc_q;
	logic [RAD_W-1:0]     rad_q;
	logic [RT_W-1:0]      root_q;
	logic [RT_W+1:0]      rrem_q;
	logic [SCL_W-1:0]     scl_q;
	logic                 out_valid_q;
	logic [KMH_W-1:0]     out_data_q;

	logic [DIV_W-1:0]     dvd_d  [NUM_AXES];
	logic [CNT_W-1:0]     drem_d [NUM_AXES];
	logic [CNT_W:0]       b1     [NUM_AXES];
	logic [CNT_W:0]       b2     [NUM_AXES];
	logic [QUO_W-1:0]     sq_sel;
	logic [2*RT_W+1:0]    r1;
	logic [2*RT_W+1:0]    r2;
	logic [X18_W-1:0]     x18;
	logic [KF_W-1:0]      kmh_full;
	logic [KMH_W-1:0]     kmh_sat;
	logic                 out_load;
	logic                 last_div;
	logic                 last_root;

	// one restoring division step: returns {quotient bit, remainder}
	function automatic logic [CNT_W:0] div_bit(input logic [CNT_W-1:0] r, input logic b,
		input logic [CNT_W-1:0] c);
		logic [CNT_W:0] t;
		logic [CNT_W:0] t_sub;
		t     = {r, b};
		t_sub = t - {1'b0, c};
		if (t >= {1'b0, c}) begin
			return {1'b1, t_sub[CNT_W-1:0]};
		end
		return {1'b0, t[CNT_W-1:0]};
	endfunction

	// one digit-by-digit square root step: returns {root, remainder}
	function automatic logic [2*RT_W+1:0] root_bit(input logic [RT_W+1:0] rem,
		input logic [RT_W-1:0] root, input logic [1:0] pair);
		logic [RT_W+3:0] t;
		logic [RT_W+3:0] trial;
		t     = {rem, pair};
		trial = {2'b00, root, 2'b01};
		if (t >= trial) begin
			t = t - trial;
			return {root[RT_W-2:0], 1'b1, t[RT_W+1:0]};
		end
		return {root[RT_W-2:0], 1'b0, t[RT_W+1:0]};
	endfunction

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			b1[a]     = div_bit(drem_q[a], dvd_q[a][DIV_W-1], cnt_q);
			b2[a]     = div_bit(b1[a][CNT_W-1:0], dvd_q[a][DIV_W-2], cnt_q);
			drem_d[a] = b2[a][CNT_W-1:0];
			dvd_d[a]  = {dvd_q[a][DIV_W-3:0], b1[a][CNT_W], b2[a][CNT_W]};
		end
	end

	always_comb begin
		case (step_q)
			STEP_W'(0): sq_sel = dvd_q[0][QUO_W-1:0];
			STEP_W'(1): sq_sel = dvd_q[1][QUO_W-1:0];
			default:    sq_sel = dvd_q[2][QUO_W-1:0];
		endcase
	end

	assign r1 = root_bit(rrem_q, root_q, rad_q[RAD_W-1 -: 2]);
	assign r2 = root_bit(r1[RT_W+1:0], r1[2*RT_W+1:RT_W+2], rad_q[RAD_W-3 -: 2]);

	assign x18      = X18_W'({root_q, 4'b0000}) + X18_W'({root_q, 1'b0});
	assign kmh_full = scl_q[SCL_W-1:RECIP_SH];
	assign kmh_sat  = (kmh_full > KF_W'(OUT_MAX)) ? KMH_W'(OUT_MAX) : kmh_full[KMH_W-1:0];

	assign last_div  = (step_q == STEP_W'(DIV_CYC - 1));
	assign last_root = (step_q == STEP_W'(ROOT_CYC - 1));
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || m_tready);
	assign q_ready   = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (q_valid) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (last_div) begin
						step_q  <= '0;
						state_q <= ST_SQR;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_SQR: begin
					if (step_q == STEP_W'(3)) begin
						step_q  <= '0;
						state_q <= ST_ROOT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_ROOT: begin
					if (last_root) begin
						step_q  <= '0;
						state_q <= ST_SCALE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_SCALE: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cnt_q <= q_item.cnt;
				acc_q <= '0;
				for (int a = 0; a < NUM_AXES; a++) begin
					dvd_q[a]  <= DIV_W'(q_item.abs_sum[a]);
					drem_q[a] <= '0;
				end
			end
			ST_DIV: begin
				for (int a = 0; a < NUM_AXES; a++) begin
					dvd_q[a]  <= dvd_d[a];
					drem_q[a] <= drem_d[a];
				end
			end
			ST_SQR: begin
				// multiply in steps 0..2, accumulate the registered product in the step after
				prod_q <= sq_sel * sq_sel;
				if (step_q != '0) begin
					acc_q <= acc_q + SQ_W'(prod_q);
				end
				if (step_q == STEP_W'(3)) begin
					rad_q  <= RAD_W'(acc_q + SQ_W'(prod_q));
					root_q <= '0;
					rrem_q <= '0;
				end
			end
			ST_ROOT: begin
				root_q <= r2[2*RT_W+1:RT_W+2];
				rrem_q <= r2[RT_W+1:0];
				rad_q  <= {rad_q[RAD_W-5:0], 4'b0000};
			end
			ST_SCALE: scl_q <= SCL_W'(x18) * SCL_W'(RECIP5);
			ST_DONE: begin
				if (out_load) begin
					out_data_q <= kmh_sat;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* src/smoothed_velocity_speed.sv */
// Top level of the smoothed velocity speed block.
`default_nettype none

// Moving-average speed magnitude. Each input transfer carries one velocity
// sample per axis (signed Q7.8 m/s); each produces exactly one output transfer
// with the speed in unsigned Q10.8 km/h, saturated at the 18-bit maximum.
// Each axis is averaged over the last window_len samples (1..8; 0 acts as 1,
// larger values as 8), or over fewer while the window is still filling, with
// truncation toward zero; the magnitude is the floor square root of the sum of
// squared averages, times 3.6 floored. A config write clears the sample store
// and must only happen while the block is idle. The front end hands each
// accepted sample to a two-entry queue as a job in the same cycle; the back
// end runs each job through load, divide (two quotient bits per cycle for all
// three axes), the shared squaring multiplier, square root (two bits per
// cycle), scale and output load, and takes the next job only once the last
// result is in the output register. The output register lets the next job run
// while a result waits for m_tready.
module smoothed_velocity_speed
	import svs_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // vel_x [15:0], vel_y [31:16], vel_z [47:32]
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,   // speed_kmh [17:0], zero fill above
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_W-1:0]       cfg_data   // window_len
);

	svs_item_t        fq_item;
	logic             fq_valid;
	logic             fq_ready;
	svs_item_t        bq_item;
	logic             bq_valid;
	logic             bq_ready;
	logic [KMH_W-1:0] speed_kmh;

	// front: windows, running sums, window length
	svs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata[IN_W-1:0]),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.q_valid   (fq_valid),
		.q_ready   (fq_ready),
		.q_item    (fq_item)
	);

	// decouples the front end from the back end, which works through each job step by step
	svs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_item   (fq_item),
		.out_valid (bq_valid),
		.out_ready (bq_ready),
		.out_item  (bq_item)
	);

	// back: divide, square, root, scale, output register
	svs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (bq_valid),
		.q_ready  (bq_ready),
		.q_item   (bq_item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (speed_kmh)
	);

	assign m_tdata = OUT_TDATA_W'(speed_kmh);

endmodule

`default_nettype wire

/* sim/svs_checker.sv */
// Transfer monitor, speed predictor and result comparator for smoothed_velocity_speed.
module svs_checker
	import svs_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // vel_x [15:0], vel_y [31:16], vel_z [47:32]
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	input  wire logic [OUT_TDATA_W-1:0] m_tdata,   // speed_kmh [17:0], zero fill above
	input  wire logic                   cfg_valid,
	input  wire logic                   cfg_ready,
	input  wire logic [CFG_W-1:0]       cfg_data,  // window_len
	output int                          fail_count,
	output int                          pending
);

	localparam int PRINT_MAX = 20;

	logic [CFG_W-1:0]  win_len;
	longint            hist [NUM_AXES][MAX_WINDOW];
	longint            run_sum [NUM_AXES];
	int                held;
	int                next_slot;
	logic [KMH_W-1:0]  speed_q [$];

	initial fail_count = 0;

	task automatic clear_store();
		for (int ax = 0; ax < NUM_AXES; ax++) begin
			run_sum[ax] = 0;
			for (int i = 0; i < MAX_WINDOW; i++)
				hist[ax][i] = 0;
		end
		held      = 0;
		next_slot = 0;
	endtask

	function automatic longint floor_sqrt(longint n);
		longint root;
		longint bitv;
		root = 0;
		bitv = longint'(1) << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n    = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// push one sample into the windows, return the smoothed speed
	function automatic logic [KMH_W-1:0] next_speed(sample_t vx, sample_t vy, sample_t vz);
		sample_t v [NUM_AXES];
		int      eff;
		int      slot;
		longint  avg;
		longint  sq;
		longint  kmh;
		v[0] = vx;
		v[1] = vy;
		v[2] = vz;
		eff  = (win_len == 0) ? 1 : ((win_len > MAX_WINDOW) ? MAX_WINDOW : int'(win_len));
		slot = next_slot % eff;
		if (held >= eff) begin
			for (int ax = 0; ax < NUM_AXES; ax++)
				run_sum[ax] -= hist[ax][slot];
		end else begin
			held++;
		end
		for (int ax = 0; ax < NUM_AXES; ax++) begin
			hist[ax][slot] = v[ax];
			run_sum[ax] += v[ax];
		end
		next_slot = (slot + 1) % eff;
		sq = 0;
		for (int ax = 0; ax < NUM_AXES; ax++) begin
			avg = run_sum[ax] / longint'(held);   // truncates toward zero
			if (avg < 0)
				avg = -avg;
			sq += avg * avg;
		end
		kmh = (floor_sqrt(sq) * 18) / 5;
		if (kmh > OUT_MAX)
			kmh = OUT_MAX;
		return kmh[KMH_W-1:0];
	endfunction

	task automatic report(string what, int unsigned want, int unsigned got);
		if (fail_count < PRINT_MAX)
			$display("%0t %s: want %0d got %0d", $time, what, want, got);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len = CFG_W'(LEN_RESET);
			clear_store();
			speed_q.delete();
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (speed_q.size() == 0) begin
					report("speed_kmh with nothing expected", 0, m_tdata[KMH_W-1:0]);
				end else if (m_tdata[KMH_W-1:0] != speed_q[0]) begin
					report("speed_kmh wrong", speed_q[0], m_tdata[KMH_W-1:0]);
					void'(speed_q.pop_front());
				end else begin
					void'(speed_q.pop_front());
				end
			end
			if (cfg_valid && cfg_ready) begin
				win_len = cfg_data;
				clear_store();
			end
			if (s_tvalid && s_tready)
				speed_q.push_back(next_speed(s_tdata[SAMPLE_BITS-1:0],
					s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS],
					s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]));
			pending = speed_q.size();
		end
	end

endmodule

/* sim/tb_smoothed_velocity_speed.sv */
// Stimulus, reset, timeout and verdict for the smoothed_velocity_speed block.
module tb_smoothed_velocity_speed;
	import svs_pkg::*;

	// hang guard, set with a wide margin over the slowest legal run
	localparam int CYCLE_LIMIT = 600000;
	localparam int SUB_ITEMS   = 125;   // items per window setting in the random part

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;    // vel_x [15:0], vel_y [31:16], vel_z [47:32]
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;    // speed_kmh [17:0], zero fill above
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_W-1:0]       cfg_data;   // window_len

	int send_idle;    // percent of cycles the sender holds back
	int recv_stall;   // percent of cycles the receiver drops tready
	int fail_count;
	int pending;      // results predicted but not yet seen
	int cycles;

	// idle mix per random phase: none, sender only, receiver only, both
	int idle_mix [4][2] = '{'{0, 0}, '{51, 0}, '{0, 51}, '{24, 24}};

	smoothed_velocity_speed dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	svs_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop if the block hangs
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("smoothed_velocity_speed: mismatch");
			$finish;
		end
	end

	// receiver back-pressure, one decision per cycle on the falling edge
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall);

	// one sample transfer; returns at the rising edge that accepted it, so a
	// following call can keep tvalid high without a low blip
	task automatic send_velocity(input sample_t vx, input sample_t vy, input sample_t vz);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {vz, vy, vx};
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and wait until every predicted speed has come out
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// window_len is only written with the block idle
	task automatic write_len(input logic [CFG_W-1:0] len);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= len;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic sample_t rand_vel();
		case ($urandom_range(3))
			0: return sample_t'($urandom);
			1: return sample_t'(int'($urandom_range(600)) - 300);
			2: begin
				case ($urandom_range(3))
					0: return 16'sh7fff;
					1: return 16'sh8000;
					2: return -16'sd1;
					default: return 16'sd0;
				endcase
			end
			default: begin
				// near full scale, either sign
				if ($urandom_range(1))
					return sample_t'(int'($urandom_range(32767, 30000)));
				else
					return sample_t'(-int'($urandom_range(32768, 30000)));
			end
		endcase
	endfunction

	// mostly in-range window lengths, with the out-of-range ones now and then
	function automatic logic [CFG_W-1:0] rand_len();
		if ($urandom_range(9) < 8)
			return CFG_W'($urandom_range(MAX_WINDOW, 1));
		return CFG_W'($urandom);
	endfunction

	initial begin
		sample_t bx, by, bz;
		int      run;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		m_tready   = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		send_idle  = 0;
		recv_stall = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset window length of 5, field extremes, wrap past a full window
		send_velocity(16'sd0, 16'sd0, 16'sd0);
		send_velocity(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_velocity(16'sh8000, 16'sh8000, 16'sh8000);
		send_velocity(-16'sd1, -16'sd1, -16'sd1);
		send_velocity(16'sd1, 16'sd0, -16'sd1);
		send_velocity(16'sh7fff, 16'sh8000, 16'sd0);
		send_velocity(16'sd256, 16'sd0, 16'sd0);
		send_velocity(16'sd0, -16'sd256, 16'sh5555);

		// length above the window size saturates to 8; largest magnitude
		write_len(4'd15);
		send_velocity(16'sh8000, 16'sh8000, 16'sh8000);
		send_velocity(16'sh8000, 16'sh8000, 16'sh8000);
		send_velocity(16'sh7fff, 16'sh8000, 16'sh2aaa);

		// length zero behaves as a single sample
		write_len(4'd0);
		send_velocity(16'sh7fff, 16'sh8000, 16'sh7fff);
		send_velocity(-16'sd1, 16'sd1, 16'sd0);
		send_velocity(16'sd3, -16'sd7, 16'sd0);

		write_len(4'd1);
		send_velocity(16'sd100, -16'sd100, 16'sd5);
		send_velocity(16'sh8000, 16'sd0, 16'sd0);

		// full window of 8, then one more to drop the oldest
		write_len(4'd8);
		for (int i = 0; i < 9; i++)
			send_velocity((i % 2) ? 16'sh8000 : 16'sh7fff, 16'sh0100, -16'sd3);

		// random part: each idle mix, several window settings per mix
		for (int p = 0; p < 4; p++) begin
			for (int s = 0; s < 3; s++) begin
				write_len((p == 0 && s == 0) ? 4'd8 : rand_len());
				send_idle  = idle_mix[p][0];
				recv_stall = idle_mix[p][1];
				run = 0;
				for (int i = 0; i < SUB_ITEMS; i++) begin
					// sender holds off until the pipe is empty, once per mix
					if (s == 1 && i == SUB_ITEMS / 2)
						drain();
					// steady runs of a base velocity plus noise, or unrelated samples
					if (run == 0) begin
						run = $urandom_range(20, 1);
						bx  = rand_vel();
						by  = rand_vel();
						bz  = rand_vel();
					end
					run--;
					if ($urandom_range(2) == 0)
						send_velocity(rand_vel(), rand_vel(), rand_vel());
					else
						send_velocity(bx + sample_t'(int'($urandom_range(64)) - 32),
							by + sample_t'(int'($urandom_range(64)) - 32),
							bz + sample_t'(int'($urandom_range(64)) - 32));
				end
			end
		end

		send_idle  = 0;
		recv_stall = 0;
		drain();
		repeat (60) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("smoothed_velocity_speed: match");
		else
			$display("smoothed_velocity_speed: mismatch");
		$finish;
	end

endmodule

/* smoothed_velocity_speed.f */
src/svs_pkg.sv
src/svs_front.sv
src/svs_queue.sv
src/svs_back.sv
src/smoothed_velocity_speed.sv
sim/svs_checker.sv
sim/tb_smoothed_velocity_speed.sv
